FILE: src/sfr_pkg.sv
// Shared types and constants of the stream find and replace unit.
`default_nettype none

package sfr_pkg;

    localparam int BYTE_W      = 8;
    localparam int FILL_W      = 3;
    localparam int CNT_W       = 4;
    localparam int JOB_BYTES   = 8;
    localparam int JOB_W       = BYTE_W * JOB_BYTES;
    localparam int IDX_W       = 3;
    localparam int COUNT_W     = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_BYTES      = 2'd0,
        CFG_PATTERN_LENGTH     = 2'd1,
        CFG_REPLACEMENT_BYTES  = 2'd2,
        CFG_REPLACEMENT_LENGTH = 2'd3
    } cfg_index_t;

    // One classified input item: the result bytes it releases and their tags.
    typedef struct packed {
        logic [JOB_W-1:0]   data;
        logic [CNT_W-1:0]   cnt;
        logic               byte_valid;
        logic               text_end;
        logic [COUNT_W-1:0] match_count;
    } job_t;

endpackage

`default_nettype wire

FILE: src/sfr_front.sv
// Front end: configuration registers, match window and per-request classification.
`default_nettype none

module sfr_front
    import sfr_pkg::*;
#(
    parameter int MAX_PATTERN = 8
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  accept,
    input  wire logic [BYTE_W-1:0]     text_byte,
    input  wire logic                  text_end,
    output logic                       push,
    output job_t                       job
);

    localparam int WIN_W = BYTE_W * MAX_PATTERN;
    localparam logic [CNT_W-1:0] PLEN_MAX = CNT_W'(MAX_PATTERN);
    localparam logic [CNT_W-1:0] RLEN_MAX = CNT_W'(JOB_BYTES);

    logic [CFG_DATA_W-1:0] pattern_bytes_reg;
    logic [CNT_W-1:0]      pattern_length_reg;
    logic [CFG_DATA_W-1:0] replacement_bytes_reg;
    logic [CNT_W-1:0]      replacement_length_reg;

    logic [WIN_W-1:0]   window_reg, window_next;
    logic [FILL_W-1:0]  window_fill_reg, window_fill_next;
    logic [COUNT_W-1:0] replace_total_reg, replace_total_next;

    logic [CNT_W-1:0]   plen, rlen, n, drop, start, cnt;
    logic [WIN_W-1:0]   buf_vec;
    logic [JOB_W-1:0]   buf_wide;
    logic               hit, use_repl, bump;
    logic [COUNT_W-1:0] total_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bytes_reg      <= '0;
            pattern_length_reg     <= CNT_W'(1);
            replacement_bytes_reg  <= '0;
            replacement_length_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_PATTERN_BYTES:      pattern_bytes_reg      <= cfg_data;
                CFG_PATTERN_LENGTH:     pattern_length_reg     <= cfg_data[CNT_W-1:0];
                CFG_REPLACEMENT_BYTES:  replacement_bytes_reg  <= cfg_data;
                CFG_REPLACEMENT_LENGTH: replacement_length_reg <= cfg_data[CNT_W-1:0];
                default:                ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_fill_reg   <= '0;
            replace_total_reg <= '0;
        end
        else if (accept)
        begin
            window_fill_reg   <= window_fill_next;
            replace_total_reg <= replace_total_next;
        end
    end

    // Window bytes carry no reset; only entries below the fill level are used.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            window_reg <= window_next;
        end
    end

    always_comb
    begin
        if (pattern_length_reg == '0)
            plen = CNT_W'(1);
        else if (pattern_length_reg > PLEN_MAX)
            plen = PLEN_MAX;
        else
            plen = pattern_length_reg;

        if (replacement_length_reg > RLEN_MAX)
            rlen = RLEN_MAX;
        else
            rlen = replacement_length_reg;

        n = {1'b0, window_fill_reg} + CNT_W'(1);

        // Append the new byte right after the held bytes.
        buf_vec = '0;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if (CNT_W'(i) < {1'b0, window_fill_reg})
                buf_vec[i*BYTE_W +: BYTE_W] = window_reg[i*BYTE_W +: BYTE_W];
            else if (CNT_W'(i) == {1'b0, window_fill_reg})
                buf_vec[i*BYTE_W +: BYTE_W] = text_byte;
        end

        buf_wide = '0;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            buf_wide[i*BYTE_W +: BYTE_W] = buf_vec[i*BYTE_W +: BYTE_W];
        end

        hit = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if ((CNT_W'(i) < plen) &&
                (buf_vec[i*BYTE_W +: BYTE_W] != pattern_bytes_reg[i*BYTE_W +: BYTE_W]))
                hit = 1'b0;
        end

        drop     = n - plen + CNT_W'(1);
        use_repl = 1'b0;
        bump     = 1'b0;
        if (n > plen)
        begin
            // Pattern was shortened: release the oldest bytes, no compare.
            start = drop;
            cnt   = text_end ? n : drop;
        end
        else if (n == plen)
        begin
            if (hit)
            begin
                use_repl = 1'b1;
                bump     = 1'b1;
                start    = n;
                cnt      = rlen;
            end
            else
            begin
                start = CNT_W'(1);
                cnt   = text_end ? n : CNT_W'(1);
            end
        end
        else
        begin
            start = '0;
            cnt   = text_end ? n : '0;
        end

        if (bump && (replace_total_reg != '1))
            total_inc = replace_total_reg + COUNT_W'(1);
        else
            total_inc = replace_total_reg;

        window_next = buf_vec >> {start, 3'b000};
        if (text_end)
        begin
            window_fill_next   = '0;
            replace_total_next = '0;
        end
        else
        begin
            window_fill_next   = FILL_W'(n - start);
            replace_total_next = total_inc;
        end

        job.data        = use_repl ? replacement_bytes_reg : buf_wide;
        job.cnt         = cnt;
        job.byte_valid  = 1'b1;
        job.text_end    = text_end;
        job.match_count = total_inc;
        // An end item that leaves nothing to write becomes a bare end marker.
        if (text_end && (cnt == '0))
        begin
            job.data       = '0;
            job.cnt        = CNT_W'(1);
            job.byte_valid = 1'b0;
        end

        push = accept && ((cnt != '0) || text_end);
    end

endmodule

`default_nettype wire

FILE: src/sfr_queue.sv
// Short queue of classified requests between the front and back ends.
`default_nettype none

module sfr_queue
    import sfr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  job_t      push_job,
    output logic      push_ready,
    input  wire logic pop,
    output logic      head_valid,
    output job_t      head
);

    job_t              entry_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_mem[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + QCNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_mem[wr_ptr_reg] <= push_job;
    end

endmodule

`default_nettype wire

FILE: src/sfr_back.sv
// Back end: walks the bytes of each queued request into the output register.
`default_nettype none

module sfr_back
    import sfr_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      head_valid,
    input  job_t                           head,
    output logic                           pop,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [BYTE_W+COUNT_W-1:0]      m_tdata,
    output logic                           m_tuser,
    output logic                           m_tlast
);

    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]  out_byte_reg;
    logic               out_bvalid_reg;
    logic               out_last_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic               load, at_last;
    logic [IDX_W-1:0]   last_idx;

    always_comb
    begin
        load     = head_valid && (!out_valid_reg || m_tready);
        last_idx = IDX_W'(head.cnt - CNT_W'(1));
        at_last  = (idx_reg == last_idx);
        pop      = load && at_last;

        idx_next = idx_reg;
        if (load)
            idx_next = at_last ? '0 : idx_reg + IDX_W'(1);

        if (load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg   <= head.data[{idx_reg, 3'b000} +: BYTE_W];
            out_bvalid_reg <= head.byte_valid;
            out_last_reg   <= head.text_end && at_last;
            out_count_reg  <= head.match_count;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_count_reg, out_byte_reg};
    assign m_tuser  = out_bvalid_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

FILE: src/stream_find_and_replace_unit.sv
// Top level of the stream find and replace unit.
//
//  Channel  Direction  Handshake                 Contents
//  s_*      in         s_tvalid / s_tready       one text byte, tlast ends the text
//  m_*      out        m_tvalid / m_tready       one output byte or bare end marker
//  cfg_*    in         cfg_valid / cfg_ready     register index and write data
//
// The unit takes one input request per cycle. The front end compares the
// window of held bytes with the pattern in the same cycle and hands the
// bytes it releases, up to eight, to a four-entry queue. The back end
// delivers one result per cycle while m_tready is high, so a request with
// k results holds it until all are out; input stalls only while the queue is full.
// Reset clears the fill level, the replacement count, the queue and the
// output valid; window bytes are never read before they are written.
// Configuration writes are always taken (cfg_ready is tied high).
`default_nettype none

module stream_find_and_replace_unit
    import sfr_pkg::*;
#(
    parameter int MAX_PATTERN = 8
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // Input stream.
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [BYTE_W-1:0]          s_tdata,   // [7:0] text_byte
    input  wire logic                       s_tlast,   // text_end
    // Output stream.
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [BYTE_W+COUNT_W-1:0]       m_tdata,   // [7:0] out_byte, [23:8] match_count
    output logic                            m_tuser,   // [0] byte_valid
    output logic                            m_tlast,   // out_end
    // Configuration writes.
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [CFG_DATA_W-1:0]      cfg_data
);

    logic accept;
    logic push, push_ready;
    logic pop, head_valid;
    job_t push_job, head;

    // The user must write configuration only while idle; the block does not enforce this, so writes need no stall.
    assign cfg_ready = 1'b1;

    // A request is taken whenever the queue has room for its results.
    assign s_tready = push_ready;
    assign accept   = s_tvalid && push_ready;

    sfr_front #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .text_byte (s_tdata),
        .text_end  (s_tlast),
        .push      (push),
        .job       (push_job)
    );

    sfr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .push_ready (push_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    sfr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

FILE: src/sfr_checker.sv
// Port-level assertions of the stream find and replace unit and their bind.
`default_nettype none

module sfr_checker
    import sfr_pkg::*;
(
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      s_tready,
    input wire logic                      m_tvalid,
    input wire logic                      m_tready,
    input wire logic [BYTE_W+COUNT_W-1:0] m_tdata,
    input wire logic                      m_tuser,
    input wire logic                      m_tlast,
    input wire logic                      cfg_ready
);

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("stalled output request changed");

    // A result without a byte is only ever the end marker of a text.
    a_bare_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tlast)
        else $error("bare marker without end flag");

    // A bare end marker carries a zero byte.
    a_bare_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> (m_tdata[BYTE_W-1:0] == '0))
        else $error("bare marker with nonzero byte");

    // Reset empties the output register and leaves both input sides ready.
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid && s_tready && cfg_ready)
        else $error("unit not idle during reset");

endmodule

bind stream_find_and_replace_unit sfr_checker u_sfr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_ready (cfg_ready)
);

`default_nettype wire
